// ===== sv/cpk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpk_pkg: shared types and constants
// Sizes of the factor store, the top list and the search registers.
// ----------------------------------------------------------------------------
package cpk_pkg;
	localparam int MAX_MATS = 4;
	localparam int MAX_COLS = 256;
	localparam int MAX_RANK = 16;
	localparam int MAX_TOP = 64;
	localparam int MAT_W = 2;
	localparam int COL_W = 8;
	localparam int RANK_W = 4;
	localparam int ADDR_W = MAT_W + COL_W + RANK_W;
	localparam int TOP_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_RANK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COL1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COL2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COL3 = 3'd6;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic [0:0] cmd;
		logic [MAT_W-1:0] mat_sel;
		logic [COL_W-1:0] column;
		logic [RANK_W-1:0] rank_pos;
		logic signed [15:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [0:0] last_flag;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_MUL, ST_INS, ST_CHK, ST_SHIFT, ST_STEP, ST_EMIT_RD, ST_EMIT
	} state_t;
endpackage

// ===== sv/cpk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpk_in_if / cpk_out_if: request channels
// Valid and ready handshake carrying the input and result items.
// ----------------------------------------------------------------------------
interface cpk_in_if;
	logic valid;
	logic ready;
	cpk_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cpk_out_if;
	logic valid;
	logic ready;
	cpk_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cp_tensor_top_k_search_top.sv =====
`timescale 1ns / 1ps
// A load request writes one factor entry; requests are accepted
// only while the block is idle. A start request walks every column tuple; each
// tuple does a factor memory read and a multiply per entry, then a fetch from
// the sorted list memory, a compare against the smallest kept value when the
// list already holds top_count values, a step per list entry moved plus one
// to place the value, and an advance of the tuple counter. The kept values
// are then emitted, each read from the list memory and then held until the
// result is taken.
// ----------------------------------------------------------------------------
// cp_tensor_top_k_search_top: exhaustive top-k search over a CP tensor
// Factor store memory, mixed-radix tuple walk and a sorted top list memory.
// ----------------------------------------------------------------------------
module cp_tensor_top_k_search_top (
	input logic clk,
	input logic arst_n,
	cpk_in_if.sink in_ch,
	cpk_out_if.source out_ch,
	input logic cfg_we,
	input logic [cpk_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cpk_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cpk_pkg::*;

	logic [4:0] rank_q;
	logic [2:0] mats_q;
	logic [6:0] top_q;
	logic [8:0] cols_q [MAX_MATS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= 5'd1;
			mats_q <= 3'd2;
			top_q <= 7'd8;
			for (int i = 0; i < MAX_MATS; i++) cols_q[i] <= 9'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANK: rank_q <= cfg_data[4:0];
				REG_MATS: mats_q <= cfg_data[2:0];
				REG_TOP: top_q <= cfg_data[6:0];
				REG_COL0: cols_q[0] <= cfg_data;
				REG_COL1: cols_q[1] <= cfg_data;
				REG_COL2: cols_q[2] <= cfg_data;
				REG_COL3: cols_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped search limits, latched at start.
	logic [4:0] ranks_q;
	logic [2:0] nmats_q;
	logic [6:0] keep_q;
	logic [8:0] radix_q [MAX_MATS];

	state_t state_q, state_d;
	logic [COL_W-1:0] digit_q [MAX_MATS];
	logic [RANK_W-1:0] r_q;
	logic [MAT_W-1:0] m_q;
	logic signed [15:0] prod_q;
	logic signed [31:0] sum_q;
	logic [6:0] count_q;
	logic [6:0] pos_q;
	logic [6:0] k_q;
	logic signed [31:0] val_q;

	// Factor memory.
	logic signed [15:0] fmem [MAX_MATS*MAX_COLS*MAX_RANK];
	logic signed [15:0] frd_q;
	logic [ADDR_W-1:0] faddr;
	logic fwe;

	// Top list memory.
	logic signed [31:0] lmem [MAX_TOP];
	logic signed [31:0] lrd_q;
	logic [TOP_W-1:0] lra, lwa;
	logic lwe;
	logic signed [31:0] lwd;

	logic in_acc, out_acc;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;

	assign fwe = in_acc && in_ch.data.cmd == CMD_LOAD;
	assign faddr = fwe ? {in_ch.data.mat_sel, in_ch.data.column, in_ch.data.rank_pos}
		: {m_q, digit_q[m_q], r_q};

	always_ff @(posedge clk) begin
		if (fwe) fmem[faddr] <= in_ch.data.entry_value;
		frd_q <= fmem[faddr];
		if (lwe) lmem[lwa] <= lwd;
		lrd_q <= lmem[lra];
	end

	// Q1.15 product and saturated accumulation.
	logic signed [31:0] pmul;
	logic signed [16:0] pq;
	logic signed [15:0] pnext;
	logic signed [32:0] sadd;
	logic signed [31:0] snext;
	logic last_m, last_r;
	always_comb begin
		pmul = prod_q * frd_q;
		pq = pmul[31:15];
		if (pq > 17'sd32767) pnext = 16'sd32767;
		else if (pq < -17'sd32768) pnext = -16'sd32768;
		else pnext = pq[15:0];
		if (m_q == '0) pnext = frd_q;
		sadd = {sum_q[31], sum_q} + {{17{pnext[15]}}, pnext};
		if (sadd[32] != sadd[31]) snext = sadd[32] ? 32'sh80000000 : 32'sh7fffffff;
		else snext = sadd[31:0];
		last_m = {1'b0, m_q} == nmats_q - 3'd1;
		last_r = {1'b0, r_q} == ranks_q - 5'd1;
	end

	// A full list first compares against its smallest entry; a value that is
	// not larger is dropped. Otherwise smaller entries move down one slot at a
	// time until the value finds its place.
	logic full;
	assign full = count_q >= keep_q;
	logic [6:0] tail;
	assign tail = full ? keep_q - 7'd1 : count_q;
	logic move_down;
	assign move_down = pos_q != 7'd0 && lrd_q < val_q;

	// Tuple counter advance, digit zero fastest.
	logic walk_done;
	logic [COL_W-1:0] dig_n [MAX_MATS];
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int i = 0; i < MAX_MATS; i++) begin
			dig_n[i] = digit_q[i];
			if (carry && i < nmats_q) begin
				if ({1'b0, digit_q[i]} + 9'd1 < radix_q[i]) begin
					dig_n[i] = digit_q[i] + 8'd1;
					carry = 1'b0;
				end else dig_n[i] = '0;
			end
		end
		walk_done = carry;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc && in_ch.data.cmd == CMD_START) state_d = ST_READ;
			ST_READ: state_d = ST_MUL;
			ST_MUL: if (last_m && last_r) state_d = ST_INS; else state_d = ST_READ;
			ST_INS: state_d = full ? ST_CHK : ST_SHIFT;
			ST_CHK: state_d = (lrd_q >= val_q) ? ST_STEP : ST_SHIFT;
			ST_SHIFT: if (!move_down) state_d = ST_STEP;
			ST_STEP: if (walk_done) state_d = (count_q == 7'd0) ? ST_IDLE : ST_EMIT_RD;
				else state_d = ST_READ;
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: if (out_acc) state_d = (k_q + 7'd1 == count_q) ? ST_IDLE : ST_EMIT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// In ST_SHIFT lrd_q holds list[pos-1]; either it or the new value goes to pos.
	always_comb begin
		lwe = 1'b0;
		lwa = pos_q[TOP_W-1:0];
		lwd = val_q;
		lra = pos_q[TOP_W-1:0] - 6'd1;
		case (state_q)
			ST_INS: lra = full ? tail[TOP_W-1:0] : tail[TOP_W-1:0] - 6'd1;
			ST_SHIFT: begin
				lra = pos_q[TOP_W-1:0] - 6'd2;
				lwe = 1'b1;
				if (move_down) lwd = lrd_q;
			end
			ST_EMIT_RD: lra = k_q[TOP_W-1:0];
			ST_EMIT: lra = k_q[TOP_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			for (int i = 0; i < MAX_MATS; i++) digit_q[i] <= '0;
			r_q <= '0;
			m_q <= '0;
			k_q <= '0;
			pos_q <= '0;
			prod_q <= '0;
			sum_q <= '0;
			val_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (state_d == ST_READ) begin
					count_q <= '0;
					r_q <= '0;
					m_q <= '0;
					sum_q <= '0;
					k_q <= '0;
					for (int i = 0; i < MAX_MATS; i++) digit_q[i] <= '0;
				end
				ST_MUL: begin
					prod_q <= pnext;
					if (last_m) begin
						m_q <= '0;
						sum_q <= snext;
						val_q <= snext;
						r_q <= r_q + 4'd1;
					end else m_q <= m_q + 2'd1;
				end
				ST_INS: pos_q <= tail;
				ST_SHIFT: begin
					if (move_down) pos_q <= pos_q - 7'd1;
					else count_q <= tail + 7'd1;
				end
				ST_STEP: begin
					for (int i = 0; i < MAX_MATS; i++) digit_q[i] <= walk_done ? '0 : dig_n[i];
					r_q <= '0;
					m_q <= '0;
					sum_q <= '0;
				end
				ST_EMIT: if (out_acc) k_q <= k_q + 7'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && in_ch.data.cmd == CMD_START) begin
			ranks_q <= rank_q == 0 ? 5'd1 : (rank_q > 5'd16 ? 5'd16 : rank_q);
			nmats_q <= mats_q == 0 ? 3'd1 : (mats_q > 3'd4 ? 3'd4 : mats_q);
			keep_q <= top_q == 0 ? 7'd1 : (top_q > 7'd64 ? 7'd64 : top_q);
			for (int i = 0; i < MAX_MATS; i++)
				radix_q[i] <= cols_q[i] == 0 ? 9'd1 : (cols_q[i] > 9'd256 ? 9'd256 : cols_q[i]);
		end
	end

	assign in_ch.ready = state_q == ST_IDLE;
	assign out_ch.valid = state_q == ST_EMIT;
	assign out_ch.data.top_value = lrd_q;
	assign out_ch.data.last_flag = k_q + 7'd1 == count_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while emitting");
	a_count_le_keep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> count_q <= keep_q && k_q < count_q)
		else $error("emit index out of range");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(k_q)
		&& $stable(out_ch.data))
		else $error("stalled result lost");
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the top-k CP tensor search
// Factor entries are loaded and searches are started under a series of
// register settings. Each search is predicted inside the bench and every
// emitted value is checked in order. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
	import cpk_pkg::*;

	localparam int LIMIT = 20000000;
	localparam int SETTLE = 60;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cpk_in_if in_ch ();
	cpk_out_if out_ch ();

	cp_tensor_top_k_search_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	in_item_t pending_reqs[$];
	out_item_t expected_tops[$];
	logic signed [15:0] factor_mem[MAX_MATS*MAX_COLS*MAX_RANK];
	bit planned[MAX_MATS*MAX_COLS*MAX_RANK];
	int reg_val[7];
	int errors = 0;
	int cycles = 0;
	int gap_in = 0;
	int gap_out = 0;
	bit calm = 0;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic logic signed [15:0] q15_product(logic signed [15:0] a,
			logic signed [15:0] b);
		longint p;
		p = (longint'(a) * longint'(b)) >>> 15;
		if (p > 32767) p = 32767;
		if (p < -32768) p = -32768;
		return p[15:0];
	endfunction

	// Walks every column tuple and queues the kept values in descending order.
	function automatic void predict_search();
		int ranks, mats, keep, cnt;
		int radix[MAX_MATS];
		int dig[MAX_MATS];
		logic signed [31:0] kept[MAX_TOP];
		longint acc;
		logic signed [15:0] prod;
		logic signed [31:0] v;
		bit done;
		int pos;
		out_item_t o;
		ranks = clampi(reg_val[REG_RANK], 1, MAX_RANK);
		mats = clampi(reg_val[REG_MATS], 1, MAX_MATS);
		keep = clampi(reg_val[REG_TOP], 1, MAX_TOP);
		for (int m = 0; m < MAX_MATS; m++) begin
			radix[m] = clampi(reg_val[REG_COL0 + m], 1, MAX_COLS);
			dig[m] = 0;
		end
		cnt = 0;
		done = 0;
		while (!done) begin
			acc = 0;
			for (int r = 0; r < ranks; r++) begin
				for (int m = 0; m < mats; m++) begin
					if (m == 0) prod = factor_mem[(m*MAX_COLS + dig[m])*MAX_RANK + r];
					else prod = q15_product(prod, factor_mem[(m*MAX_COLS + dig[m])*MAX_RANK + r]);
				end
				acc += prod;
				if (acc > 64'sd2147483647) acc = 64'sd2147483647;
				if (acc < -64'sd2147483648) acc = -64'sd2147483648;
			end
			v = acc[31:0];
			// A full list only admits a value above its smallest entry.
			if (!(cnt >= keep && v <= kept[cnt-1])) begin
				if (cnt >= keep) cnt = keep - 1;
				pos = cnt;
				while (pos > 0 && kept[pos-1] < v) begin
					kept[pos] = kept[pos-1];
					pos--;
				end
				kept[pos] = v;
				cnt++;
			end
			done = 1;
			for (int m = 0; m < mats; m++) begin
				dig[m] = (dig[m] + 1) & 8'hFF;
				if (dig[m] < radix[m] && dig[m] != 0) begin
					done = 0;
					break;
				end
				dig[m] = 0;
			end
		end
		for (int k = 0; k < cnt; k++) begin
			o.top_value = kept[k];
			o.last_flag = (k == cnt - 1);
			expected_tops = {expected_tops, o};
		end
	endfunction

	// Input driver.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_in > 0) begin
				gap_in--;
				in_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_reqs.pop_front();
				if (!calm && $urandom_range(0, 9) == 0) gap_in = $urandom_range(1, 8);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Predictor update on each accepted request.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (in_ch.data.cmd == CMD_LOAD)
				factor_mem[{in_ch.data.mat_sel, in_ch.data.column, in_ch.data.rank_pos}] =
					in_ch.data.entry_value;
			else
				predict_search();
		end
	end

	// Result side: random back-pressure and in-order checking.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_tops.size() == 0) begin
					$display("%0t: unexpected result value=%0d last=%0b", $time,
						out_ch.data.top_value, out_ch.data.last_flag);
					errors++;
				end else begin
					if (out_ch.data.top_value !== expected_tops[0].top_value) begin
						$display("%0t: top_value expected %0d actual %0d", $time,
							expected_tops[0].top_value, out_ch.data.top_value);
						errors++;
					end
					if (out_ch.data.last_flag !== expected_tops[0].last_flag) begin
						$display("%0t: last_flag expected %0b actual %0b", $time,
							expected_tops[0].last_flag, out_ch.data.last_flag);
						errors++;
					end
					void'(expected_tops.pop_front());
				end
			end
			if (gap_out > 0) begin
				gap_out--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) gap_out = $urandom_range(1, 8);
			end
		end
	end

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_reqs.size() != 0 || in_ch.valid || expected_tops.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(int idx, int val);
		int masked;
		masked = (idx == REG_RANK) ? (val & 'h1F) : (idx == REG_MATS) ? (val & 'h7) :
			(idx == REG_TOP) ? (val & 'h7F) : (val & 'h1FF);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx[CFG_IDX_W-1:0];
		cfg_data <= masked[CFG_DATA_W-1:0];
		reg_val[idx] = masked;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_load(int m, int c, int r, logic signed [15:0] val);
		in_item_t it;
		it.cmd = CMD_LOAD;
		it.mat_sel = m[MAT_W-1:0];
		it.column = c[COL_W-1:0];
		it.rank_pos = r[RANK_W-1:0];
		it.entry_value = val;
		planned[{it.mat_sel, it.column, it.rank_pos}] = 1'b1;
		pending_reqs = {pending_reqs, it};
	endtask

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'($urandom());
		endcase
	endfunction

	// Loads every entry the search will read that is not yet defined, then starts.
	task automatic push_start();
		int ranks, mats;
		in_item_t it;
		ranks = clampi(reg_val[REG_RANK], 1, MAX_RANK);
		mats = clampi(reg_val[REG_MATS], 1, MAX_MATS);
		for (int m = 0; m < mats; m++)
			for (int c = 0; c < clampi(reg_val[REG_COL0 + m], 1, MAX_COLS); c++)
				for (int r = 0; r < ranks; r++)
					if (!planned[(m*MAX_COLS + c)*MAX_RANK + r]) push_load(m, c, r, rand_entry());
		it.cmd = CMD_START;
		it.mat_sel = 2'($urandom_range(0, 3));
		it.column = 8'($urandom_range(0, 255));
		it.rank_pos = 4'($urandom_range(0, 15));
		it.entry_value = 16'($urandom());
		pending_reqs = {pending_reqs, it};
	endtask

	task automatic run_phase(int rk, int ms, int tp, int c0, int c1, int c2, int c3,
			int nreq);
		wait_idle();
		write_reg(REG_RANK, rk);
		write_reg(REG_MATS, ms);
		write_reg(REG_TOP, tp);
		write_reg(REG_COL0, c0);
		write_reg(REG_COL1, c1);
		write_reg(REG_COL2, c2);
		write_reg(REG_COL3, c3);
		for (int i = 0; i < nreq; i++) begin
			if ($urandom_range(0, 6) == 0)
				push_start();
			else
				push_load($urandom_range(0, 3),
					$urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255),
					$urandom_range(0, 15), rand_entry());
		end
		push_start();
	endtask

	function automatic int small_cols();
		return $urandom_range(0, 4) == 0 ? $urandom_range(5, 8) : $urandom_range(1, 3);
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		reg_val = '{1, 2, 8, 1, 1, 1, 1};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: one tuple, fewer than top_count. Minus one squared saturates.
		push_load(0, 0, 0, 16'sh8000);
		push_load(1, 0, 0, 16'sh8000);
		push_start();
		push_load(0, 0, 0, 16'sh7FFF);
		push_load(1, 0, 0, 16'sh8000);
		push_start();
		wait_idle();
		// Equal values across columns, both extremes and zero.
		write_reg(REG_COL0, 4);
		write_reg(REG_TOP, 3);
		push_load(0, 1, 0, 16'sh7FFF);
		push_load(0, 2, 0, 16'sh7FFF);
		push_load(0, 3, 0, 16'sh0000);
		push_start();
		push_load(0, 0, 0, 16'sh0001);
		push_load(1, 0, 0, 16'sh7FFF);
		push_start();

		// Register extremes, including out-of-range values that are clamped.
		run_phase(31, 7, 127, 0, 0, 0, 0, 4);
		run_phase(0, 0, 0, 0, 0, 0, 0, 6);
		// More tuples than kept values, and a single kept value.
		run_phase(1, 2, 64, 40, 2, 1, 1, 4);
		run_phase(2, 1, 1, 12, 1, 1, 1, 4);
		for (int p = 0; p < 4; p++)
			run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 64),
				small_cols(), small_cols(), small_cols(), small_cols(), 20);
		calm = 1;
		run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 64),
			small_cols(), small_cols(), small_cols(), small_cols(), 20);

		wait_idle();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/cpk_pkg.sv
sv/cpk_if.sv
sv/cp_tensor_top_k_search_top.sv
test/tb.sv
